// ----- rtl/tvq_pkg.sv -----
// ----------------------------------------------------------------------------
// tvq_pkg: shared types and helpers for the tree VQ color search
// Item and result structs, item kind codes, L1 distance helper.
// ----------------------------------------------------------------------------
package tvq_pkg;

  localparam int CHAN_W  = 8;
  localparam int INDEX_W = 9;
  localparam int DEPTH_W = 4;
  localparam int CODE_W  = 8;
  localparam int DIST_W  = 10;   // 3 * 255 fits

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUANT = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] node_index;
    logic [CHAN_W-1:0]  in_red;
    logic [CHAN_W-1:0]  in_green;
    logic [CHAN_W-1:0]  in_blue;
  } request_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CODE_W-1:0] leaf_code;
  } result_t;

  // Item as it travels down the chain of level cells.
  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [INDEX_W-1:0] node_index;
    rgb_t               pixel;
    rgb_t               colour;     // node color reached so far
  } cell_item_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [DIST_W-1:0] l1_dist(input rgb_t p, input rgb_t c);
    l1_dist = DIST_W'(abs_diff(p.red, c.red))
            + DIST_W'(abs_diff(p.green, c.green))
            + DIST_W'(abs_diff(p.blue, c.blue));
  endfunction

endpackage

// ----- rtl/tree_vq_color_search.sv -----
// ----------------------------------------------------------------------------
// tree_vq_color_search: tree-structured color codebook search
// Descends a binary tree of RGB centroids by L1 distance, one cell per level.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on request when start is high and busy is low. kind selects
//   a node write (node_index in heap order, root 1, children 2i and 2i+1)
//   or a pixel quantize. Writes give no result.
//   Each quantize item gives one result on result, marked by done for a
//   single cycle: leaf color and path code (last level in the LSB).
//   cfg_we/cfg_wdata set the search depth (reset 8, saturates at MAX_DEPTH);
//   write it only while no quantize item is in flight.
// Timing:
//   Fully pipelined chain of MAX_DEPTH level cells, each a registered RAM read
//   followed by a registered compare. One item per cycle outside reset; a
//   result passes the entry register and each cell's read and compare registers.
//   Items leave in order, so a write always lands before later pixels see it.
// Reset:
//   rst flushes the chain; busy is high while rst is asserted. Node RAMs
//   are not cleared: every node on a search path must be written first.
//   The receiver cannot stall; done is a pure strobe.
// ----------------------------------------------------------------------------
module tree_vq_color_search
  import tvq_pkg::*;
#(
  parameter int MAX_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  request_t           request,
  output logic               done,
  output result_t            result,
  input  logic               cfg_we,
  input  logic [DEPTH_W-1:0] cfg_wdata
);

  // Store index mask: the store has 2^(MAX_DEPTH+1) slots.
  localparam logic [INDEX_W-1:0] IDX_MASK =
    (MAX_DEPTH >= INDEX_W - 1) ? '1 : INDEX_W'((1 << (MAX_DEPTH + 1)) - 1);
  localparam int LAT = 2 * MAX_DEPTH + 1;

  logic [DEPTH_W-1:0]   tree_depth;
  rgb_t                 root;
  logic                 accept;
  logic [INDEX_W-1:0]   idx_m;
  rgb_t                 req_pix;
  cell_item_t           entry;

  cell_item_t           chain_item [MAX_DEPTH+1];
  logic [MAX_DEPTH-1:0] chain_path [MAX_DEPTH+1];

  // The chain never backs up; only reset holds items off.
  assign busy    = rst;
  assign accept  = start && !busy;
  assign idx_m   = request.node_index & IDX_MASK;
  assign req_pix = '{red: request.in_red, green: request.in_green,
                     blue: request.in_blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      tree_depth <= DEPTH_W'(8);
    end else if (cfg_we) begin
      tree_depth <= cfg_wdata;
    end
  end

  // Root color lives here; slot 0 is never read, so its writes are dropped.
  always_ff @(posedge clk) begin
    if (accept && (request.kind == KIND_WRITE) && (idx_m == INDEX_W'(1))) begin
      root <= req_pix;
    end
  end

  // Entry register: a quantize item picks up the root color on the way in.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= accept;
    end
    entry.kind       <= request.kind;
    entry.node_index <= idx_m;
    entry.pixel      <= req_pix;
    entry.colour     <= root;
  end

  assign chain_item[0] = entry;
  assign chain_path[0] = '0;

  for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_level
    tvq_cell #(.LEVEL(g), .MAX_DEPTH(MAX_DEPTH)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .tree_depth (tree_depth),
      .in_item    (chain_item[g]),
      .in_path    (chain_path[g]),
      .out_item   (chain_item[g+1]),
      .out_path   (chain_path[g+1])
    );
  end

  // Result straight from the last cell's output register.
  assign done             = chain_item[MAX_DEPTH].valid &&
                            (chain_item[MAX_DEPTH].kind == KIND_QUANT);
  assign result.out_red   = chain_item[MAX_DEPTH].colour.red;
  assign result.out_green = chain_item[MAX_DEPTH].colour.green;
  assign result.out_blue  = chain_item[MAX_DEPTH].colour.blue;
  assign result.leaf_code = CODE_W'(chain_path[MAX_DEPTH]);

  // Every quantize item yields its strobe after the fixed latency.
  a_quant_gives_done: assert property (@(posedge clk) disable iff (rst)
    (accept && (request.kind == KIND_QUANT)) |-> ##LAT done)
    else $error("quantize item lost in the chain");

  // No strobe without a matching quantize item taken earlier.
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept && (request.kind == KIND_QUANT), LAT))
    else $error("result strobe without a matching item");

  // Writes never produce a result at the end of the chain.
  a_write_no_done: assert property (@(posedge clk) disable iff (rst)
    (accept && (request.kind == KIND_WRITE)) |-> ##LAT !done)
    else $error("node write produced a result");

endmodule

// ----- rtl/tvq_ram.sv -----
// ----------------------------------------------------------------------------
// tvq_ram: generic single-port RAM
// One access per cycle (a write also reads out the old word), registered read data.
// ----------------------------------------------------------------------------
module tvq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/tvq_cell.sv -----
// ----------------------------------------------------------------------------
// tvq_cell: one tree level of the search chain
// Holds the child colors of one level in two RAMs (left, right), takes node
// writes for that level and steps a quantize item down when depth > LEVEL.
// ----------------------------------------------------------------------------
module tvq_cell
  import tvq_pkg::*;
#(
  parameter int LEVEL     = 0,
  parameter int MAX_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [DEPTH_W-1:0]   tree_depth,
  input  cell_item_t           in_item,
  input  logic [MAX_DEPTH-1:0] in_path,
  output cell_item_t           out_item,
  output logic [MAX_DEPTH-1:0] out_path
);

  localparam int AW = (LEVEL == 0) ? 1 : LEVEL;
  localparam logic [DEPTH_W-1:0] LVL = DEPTH_W'(LEVEL);

  cell_item_t           mid_item;
  logic [MAX_DEPTH-1:0] mid_path;
  logic                 wr_here;
  logic                 wr_left;
  logic                 wr_right;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        ram_addr;
  rgb_t                 left_col;
  rgb_t                 right_col;
  logic                 go_right;
  logic                 step;

  // Node n sits on level LEVEL+1 when n >> (LEVEL+1) == 1.
  assign wr_here  = in_item.valid && (in_item.kind == KIND_WRITE) &&
                    ((in_item.node_index >> (LEVEL + 1)) == INDEX_W'(1));
  assign wr_left  = wr_here && !in_item.node_index[0];
  assign wr_right = wr_here && in_item.node_index[0];
  assign wr_addr  = (LEVEL == 0) ? '0 : AW'(in_item.node_index >> 1);
  assign ram_addr = wr_here ? wr_addr : in_path[AW-1:0];

  tvq_ram #(.WIDTH($bits(rgb_t)), .DEPTH(1 << AW)) u_left (
    .clk   (clk),
    .we    (wr_left),
    .addr  (ram_addr),
    .wdata (in_item.pixel),
    .rdata (left_col)
  );

  tvq_ram #(.WIDTH($bits(rgb_t)), .DEPTH(1 << AW)) u_right (
    .clk   (clk),
    .we    (wr_right),
    .addr  (ram_addr),
    .wdata (in_item.pixel),
    .rdata (right_col)
  );

  // Tie goes right.
  assign go_right = !(l1_dist(mid_item.pixel, left_col) <
                      l1_dist(mid_item.pixel, right_col));
  assign step     = mid_item.valid && (mid_item.kind == KIND_QUANT) &&
                    (tree_depth > LVL);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_item.valid <= 1'b0;
      out_item.valid <= 1'b0;
    end else begin
      mid_item.valid <= in_item.valid;
      out_item.valid <= mid_item.valid;
    end
    mid_item.kind       <= in_item.kind;
    mid_item.node_index <= in_item.node_index;
    mid_item.pixel      <= in_item.pixel;
    mid_item.colour     <= in_item.colour;
    mid_path            <= in_path;
    out_item.kind       <= mid_item.kind;
    out_item.node_index <= mid_item.node_index;
    out_item.pixel      <= mid_item.pixel;
    if (step) begin
      out_item.colour <= go_right ? right_col : left_col;
      out_path        <= (mid_path << 1) | MAX_DEPTH'(go_right);
    end else begin
      out_item.colour <= mid_item.colour;
      out_path        <= mid_path;
    end
  end

endmodule

// ----- test/tree_vq_color_search_test.sv -----
// ----------------------------------------------------------------------------
// tree_vq_color_search_test: self-checking bench for the tree VQ color search
// Loads heap-ordered node colors, sends pixels at several search depths and
// checks every leaf color and path code against an in-bench tree walker.
// ----------------------------------------------------------------------------
module tree_vq_color_search_test
  import tvq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DEPTH    = 8;
  localparam int STORE_N      = 1 << (MAX_DEPTH + 1);
  // Writes leave no result, so wait longer than the chain latency before
  // touching the depth register.
  localparam int FLUSH_CYCLES = 2 * MAX_DEPTH + 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  request_t           request;
  logic               done;
  result_t            result;
  logic               cfg_we;
  logic [DEPTH_W-1:0] cfg_wdata;

  tree_vq_color_search #(.MAX_DEPTH(MAX_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Items waiting for the driver, and leaf results still owed by the block.
  request_t item_feed_q[$];
  result_t  leaf_exp_q[$];

  // Walker state: the block's node memory and depth as the bench sees them.
  rgb_t               node_color [STORE_N];
  logic [DEPTH_W-1:0] search_depth;

  // Plan-time shadow, used only so no search ever reads an unwritten node.
  rgb_t plan_color   [STORE_N];
  bit   plan_written [STORE_N];
  int   plan_levels;

  // Channel values that make equal distances (ties) likely.
  logic [7:0] corner_chan [6] = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff};

  int unsigned cycle_count;
  int unsigned fed_count;
  int unsigned write_count;
  int unsigned search_count;
  int unsigned tie_count;
  int unsigned deep_count;
  int unsigned checked_count;
  int unsigned errors;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [DIST_W-1:0] color_gap(input rgb_t p, input rgb_t c);
    logic [7:0] dr, dg, db;
    dr = (p.red > c.red) ? p.red - c.red : c.red - p.red;
    dg = (p.green > c.green) ? p.green - c.green : c.green - p.green;
    db = (p.blue > c.blue) ? p.blue - c.blue : c.blue - p.blue;
    return DIST_W'(dr) + DIST_W'(dg) + DIST_W'(db);
  endfunction

  function automatic rgb_t rand_color();
    rgb_t c;
    if ($urandom_range(1) == 0) begin
      c = rgb_t'($urandom);
    end else begin
      c.red   = corner_chan[$urandom_range(5)];
      c.green = corner_chan[$urandom_range(5)];
      c.blue  = corner_chan[$urandom_range(5)];
    end
    return c;
  endfunction

  // Tree walker: stores node writes, descends for pixels and queues the
  // leaf color and path code the block must return.
  task automatic walk_tree(input request_t it);
    rgb_t              px;
    int                levels;
    int                node;
    int                lnode;
    logic [DIST_W-1:0] gap_l;
    logic [DIST_W-1:0] gap_r;
    logic [CODE_W-1:0] code;
    result_t           leaf;
    px = {it.in_red, it.in_green, it.in_blue};
    if (it.kind == KIND_WRITE) begin
      node_color[it.node_index] = px;
      write_count++;
    end else begin
      levels = (search_depth > MAX_DEPTH) ? MAX_DEPTH : int'(search_depth);
      node = 1;
      code = '0;
      for (int lv = 0; lv < levels; lv++) begin
        lnode = 2 * node;
        gap_l = color_gap(px, node_color[lnode]);
        gap_r = color_gap(px, node_color[lnode + 1]);
        if (gap_l == gap_r)
          tie_count++;
        // a tie goes to the right child
        if (gap_l < gap_r) begin
          node = lnode;
          code = {code[CODE_W-2:0], 1'b0};
        end else begin
          node = lnode + 1;
          code = {code[CODE_W-2:0], 1'b1};
        end
      end
      if (levels == MAX_DEPTH)
        deep_count++;
      leaf.out_red   = node_color[node].red;
      leaf.out_green = node_color[node].green;
      leaf.out_blue  = node_color[node].blue;
      leaf.leaf_code = code;
      leaf_exp_q.insert(leaf_exp_q.size(), leaf);
      search_count++;
    end
  endtask

  task automatic plan_write(input int idx, input rgb_t c);
    request_t it;
    it.kind       = KIND_WRITE;
    it.node_index = INDEX_W'(idx);
    {it.in_red, it.in_green, it.in_blue} = c;
    plan_color[idx]   = c;
    plan_written[idx] = 1'b1;
    item_feed_q.insert(item_feed_q.size(), it);
  endtask

  // Queues one pixel. Any node on its path that was never loaded gets a
  // random color first, so partial trees are exercised but never misread.
  task automatic plan_pixel(input rgb_t px, input logic [INDEX_W-1:0] junk_idx);
    request_t it;
    int       node;
    int       lnode;
    node = 1;
    if (plan_levels == 0 && !plan_written[1])
      plan_write(1, rand_color());
    for (int lv = 0; lv < plan_levels; lv++) begin
      lnode = 2 * node;
      if (!plan_written[lnode])
        plan_write(lnode, rand_color());
      if (!plan_written[lnode + 1])
        plan_write(lnode + 1, rand_color());
      if (color_gap(px, plan_color[lnode]) < color_gap(px, plan_color[lnode + 1]))
        node = lnode;
      else
        node = lnode + 1;
    end
    it.kind       = KIND_QUANT;
    it.node_index = junk_idx;
    {it.in_red, it.in_green, it.in_blue} = px;
    item_feed_q.insert(item_feed_q.size(), it);
  endtask

  // Mostly pixels, with rewrites inside the live tree (these reshape the
  // search) and some stray writes anywhere in the store.
  task automatic random_items(input int n);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 75)
        plan_pixel(rand_color(), INDEX_W'($urandom));
      else if (roll < 93)
        plan_write($urandom_range((1 << (plan_levels + 1)) - 1, 1), rand_color());
      else
        plan_write($urandom_range(STORE_N - 1), rand_color());
    end
  endtask

  // Sampled at the falling edge so driver updates at the rising edge are
  // already settled.
  task automatic drain();
    do
      @(negedge clk);
    while (item_feed_q.size() != 0 || start || leaf_exp_q.size() != 0);
  endtask

  task automatic set_depth(input logic [DEPTH_W-1:0] v);
    drain();
    repeat (FLUSH_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    search_depth = v;
    plan_levels  = (v > MAX_DEPTH) ? MAX_DEPTH : int'(v);
  endtask

  // Driver: presents queued items, holds each until busy is low at an edge.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        walk_tree(request);
        fed_count++;
      end
      if (!start || !busy) begin
        // about 6% idle cycles, none in one long stretch of items
        if (item_feed_q.size() != 0 &&
            ((fed_count >= 600 && fed_count < 900) || $urandom_range(99) >= 6)) begin
          request <= item_feed_q.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %02h, got %02h", $time, name, want, got);
    end
  endtask

  // Monitor: done is a one-cycle strobe, the receiver never stalls.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done === 1'b1) begin
      if (leaf_exp_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, got %p", $time, result);
      end else begin
        want = leaf_exp_q.pop_front();
        check_field("out_red", want.out_red, result.out_red);
        check_field("out_green", want.out_green, result.out_green);
        check_field("out_blue", want.out_blue, result.out_blue);
        check_field("leaf_code", want.leaf_code, result.leaf_code);
        checked_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d results still owed", $time, leaf_exp_q.size());
      $display("tree_vq_color_search_test: done, errors");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    request      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    search_depth = DEPTH_W'(8);   // reset depth
    plan_levels  = MAX_DEPTH;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // full depth straight out of reset, tree filled in as paths need it
    random_items(100);

    // depth one: ties, channel extremes, slot 0 and top index writes,
    // node_index ignored on pixels
    set_depth(DEPTH_W'(1));
    plan_write(0, rgb_t'(24'hffffff));
    plan_write(511, rgb_t'(24'h123456));
    plan_write(1, rgb_t'(24'h404040));
    plan_write(2, rgb_t'(24'h101010));
    plan_write(3, rgb_t'(24'h303030));
    plan_pixel(rgb_t'(24'h202020), '0);          // equal distance, goes right
    plan_pixel(rgb_t'(24'h000000), '1);
    plan_pixel(rgb_t'(24'hffffff), '0);
    plan_pixel(rgb_t'(24'hff00ff), 9'd256);
    plan_pixel(rgb_t'(24'h00ff00), 9'd1);
    plan_write(2, rgb_t'(24'h000000));
    plan_write(3, rgb_t'(24'hffffff));
    plan_pixel(rgb_t'(24'h808080), '0);          // 384 vs 381, right
    plan_pixel(rgb_t'(24'h7f7f7f), '0);          // 381 vs 384, left
    plan_pixel(rgb_t'(24'h01fe80), '0);

    // depth zero returns the root with code 0
    set_depth(DEPTH_W'(0));
    plan_pixel(rgb_t'(24'hffffff), '0);
    plan_pixel(rgb_t'(24'h000000), '1);
    plan_write(1, rgb_t'(24'haa55aa));
    plan_pixel(rgb_t'(24'h000000), '0);
    random_items(40);

    // register above MAX_DEPTH: the search saturates at MAX_DEPTH
    set_depth(DEPTH_W'(15));
    random_items(100);

    // mid-phase the sender stops until every result is back
    set_depth(DEPTH_W'(3));
    random_items(50);
    drain();
    random_items(50);

    set_depth(DEPTH_W'(8));
    random_items(100);
    set_depth(DEPTH_W'(5));
    random_items(80);
    set_depth(DEPTH_W'(9));
    random_items(80);
    set_depth(DEPTH_W'(2));
    random_items(70);
    set_depth(DEPTH_W'(7));
    random_items(80);
    set_depth(DEPTH_W'(4));
    random_items(70);
    set_depth(DEPTH_W'(6));
    random_items(70);
    set_depth(DEPTH_W'(1));
    random_items(50);

    drain();
    repeat (FLUSH_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d node writes, %0d searches (%0d at full depth)",
             fed_count, write_count, search_count, deep_count);
    $display("%0d results checked, %0d distance ties, depth settings 0 to 15",
             checked_count, tie_count);
    if (errors == 0) begin
      $display("tree_vq_color_search_test: done, clean");
    end else begin
      $display("tree_vq_color_search_test: done, errors");
    end
    $finish;
  end

endmodule
